// ----- src/stpq_pkg.sv -----
// ----------------------------------------------------------------------------
// stpq_pkg: shared types for the sorted task queue
// Word types of both channels, the slot entry, the cell control group and the
// priority key used by every cell.
// ----------------------------------------------------------------------------
package stpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int OCC_W        = 5;
  localparam int KEY_W        = 21;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic        mandatory;
    logic [3:0]  due_month;
    logic [4:0]  due_day;
    logic [10:0] due_minute;
    logic [15:0] task_tag;
  } task_t;

  typedef struct packed {
    logic        action;
    logic        mandatory;
    logic [3:0]  due_month;
    logic [4:0]  due_day;
    logic [10:0] due_minute;
    logic [15:0] task_tag;
  } in_word_t;

  typedef struct packed {
    logic             front_valid;
    logic             front_mandatory;
    logic [3:0]       front_month;
    logic [4:0]       front_day;
    logic [10:0]      front_minute;
    logic [15:0]      front_tag;
    logic [OCC_W-1:0] occupancy;
    logic             is_full;
    logic             refused;
  } out_word_t;

  // Operation applied to every cell together
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

  // Smaller key ranks higher: mandatory first, then month, day, minute
  function automatic logic [KEY_W-1:0] key_of(input task_t t);
    key_of = {~t.mandatory, t.due_month, t.due_day, t.due_minute};
  endfunction

endpackage

// ----- src/stpq_cell.sv -----
// ----------------------------------------------------------------------------
// stpq_cell: one slot of the sorted queue
// Holds one task, compares it with the incoming task and takes its new value
// from itself, its front neighbour, its rear neighbour or the incoming task.
// ----------------------------------------------------------------------------
module stpq_cell (
  input  logic              clk,
  input  stpq_pkg::cell_ctl_t ctl,
  input  stpq_pkg::task_t   new_task,
  input  logic              occupied,
  input  stpq_pkg::task_t   prev_slot,
  input  logic              prev_ge,
  input  stpq_pkg::task_t   next_slot,
  output stpq_pkg::task_t   slot,
  output logic              ge
);
  import stpq_pkg::*;

  task_t slot_r;
  task_t slot_nxt;

  // An empty slot always lets the new task in
  assign ge   = !occupied || (key_of(slot_r) >= key_of(new_task));
  assign slot = slot_r;

  always_comb begin
    priority if (ctl.ins) begin
      priority if (prev_ge) slot_nxt = prev_slot;
      else if (ge)          slot_nxt = new_task;
      else                  slot_nxt = slot_r;
    end else if (ctl.rem) begin
      slot_nxt = next_slot;
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

// ----- src/sorted_task_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_task_priority_queue: bounded task queue kept in priority order
// A row of slot cells, front first; insert shifts the cells from the insertion point
// toward the rear, remove shifts the whole row toward the front.
// Usage:
//   Raise start with in_word; the word is taken at any edge where busy is
//   low. busy never rises, so one word may be taken every cycle.
//   action ACT_INSERT places the task ahead of every held task with an equal
//   or lower rank; ACT_REMOVE drops the front task. Insert when full and
//   remove when empty change nothing and set refused.
//   Each taken word gives exactly one result word, shown on out_word with
//   out_valid high for one cycle, in the cycle after the word is taken.
//   Throughput is one word per cycle: every cell compares against the new
//   task in parallel and shifts with its neighbour in the same cycle.
//   The result reports the front task after the update (zero when empty),
//   the occupancy and the full flag.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; slot contents are not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_task_priority_queue #(
  parameter int CAPACITY = stpq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  stpq_pkg::in_word_t  in_word,
  output logic                out_valid,
  output stpq_pkg::out_word_t out_word
);
  import stpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  out_word_t     out_word_r, out_word_nxt;

  logic      accept, is_full_now, is_empty_now;
  cell_ctl_t ctl;
  task_t     new_task;
  task_t     front_nxt;
  task_t     slot_w [CAPACITY];
  logic      ge_w   [CAPACITY];
  logic [CW+OCC_W-1:0] count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign new_task = '{mandatory:  in_word.mandatory,
                      due_month:  in_word.due_month,
                      due_day:    in_word.due_day,
                      due_minute: in_word.due_minute,
                      task_tag:   in_word.task_tag};

  assign is_full_now  = (count_r == CW'(CAPACITY));
  assign is_empty_now = (count_r == '0);

  assign ctl.ins = accept && (in_word.action == ACT_INSERT) && !is_full_now;
  assign ctl.rem = accept && (in_word.action == ACT_REMOVE) && !is_empty_now;

  always_comb begin
    priority if (ctl.ins) count_nxt = count_r + CW'(1);
    else if (ctl.rem)     count_nxt = count_r - CW'(1);
    else                  count_nxt = count_r;
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      task_t prev_s, next_s;
      logic  prev_g;

      if (i == 0) begin : g_head
        assign prev_s = new_task;
        assign prev_g = 1'b0;
      end else begin : g_body
        assign prev_s = slot_w[i-1];
        assign prev_g = ge_w[i-1];
      end

      // Last cell holds on remove; its contents are past the count anyway
      if (i == CAPACITY - 1) begin : g_tail
        assign next_s = slot_w[i];
      end else begin : g_mid
        assign next_s = slot_w[i+1];
      end

      stpq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_task  (new_task),
        .occupied  (IDX < count_r),
        .prev_slot (prev_s),
        .prev_ge   (prev_g),
        .next_slot (next_s),
        .slot      (slot_w[i]),
        .ge        (ge_w[i])
      );
    end
  endgenerate

  // Front entry after this word, as cell 0 will hold it
  always_comb begin
    priority if (ctl.ins) front_nxt = ge_w[0] ? new_task : slot_w[0];
    else if (ctl.rem)     front_nxt = slot_w[1];
    else                  front_nxt = slot_w[0];
  end

  assign count_ext = {{OCC_W{1'b0}}, count_nxt};

  always_comb begin
    out_word_nxt = '0;
    if (count_nxt != '0) begin
      out_word_nxt.front_valid     = 1'b1;
      out_word_nxt.front_mandatory = front_nxt.mandatory;
      out_word_nxt.front_month     = front_nxt.due_month;
      out_word_nxt.front_day       = front_nxt.due_day;
      out_word_nxt.front_minute    = front_nxt.due_minute;
      out_word_nxt.front_tag       = front_nxt.task_tag;
    end
    out_word_nxt.occupancy = count_ext[OCC_W-1:0];
    out_word_nxt.is_full   = (count_nxt == CW'(CAPACITY));
    out_word_nxt.refused   = accept && !ctl.ins && !ctl.rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- src/stpq_checker.sv -----
// ----------------------------------------------------------------------------
// stpq_checker: port-level checks for the sorted task queue
// Watches the channels of the top level over time; bound to every instance.
// ----------------------------------------------------------------------------
module stpq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input stpq_pkg::in_word_t  in_word,
  input logic                out_valid,
  input stpq_pkg::out_word_t out_word
);
  import stpq_pkg::*;

  logic take;
  assign take = start && !busy;

  // One result for every taken word, in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("no result after a taken word");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> !out_valid)
    else $error("result without a taken word");

  // A refused insert can only come from a full queue, which stays full
  a_insert_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    take && (in_word.action == ACT_INSERT) |=> !out_word.refused || out_word.is_full)
    else $error("insert refused while not full");

  // A refused remove can only come from an empty queue
  a_remove_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    take && (in_word.action == ACT_REMOVE) |=>
      !out_word.refused || (!out_word.front_valid && out_word.occupancy == '0))
    else $error("remove refused while not empty");

  // A newly held mandatory task leaves a mandatory task at the front
  a_mandatory_front: assert property (@(posedge clk) disable iff (!rst_n)
    take && (in_word.action == ACT_INSERT) && in_word.mandatory |=>
      out_word.refused || (out_word.front_valid && out_word.front_mandatory))
    else $error("mandatory task not at front");

endmodule

bind sorted_task_priority_queue stpq_checker u_stpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

// ----- dv/sorted_task_priority_queue_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_task_priority_queue_tb: self-checking bench for the sorted task queue
// Drives insert/remove words through the start/busy port, keeps its own sorted
// copy of the held tasks and checks every front report against it. Covers
// field extremes, equal-key ordering, full/empty refusals and long random
// traffic with fill, drain and balanced phases and random gaps.
// ----------------------------------------------------------------------------
module sorted_task_priority_queue_tb;
  import stpq_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 16;
  localparam int PHASE_WORDS = 100;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  // Our copy of the queue, front first
  task_t     held_tasks [DEPTH];
  int        held_count;
  out_word_t front_reports_due [$];

  int mismatches = 0;
  int words_sent;
  int reports_checked = 0;
  int refusals;
  int full_hits;
  int tie_inserts;
  int idle_cycles = 0;

  sorted_task_priority_queue #(.CAPACITY(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // -1: held task ranks higher, 0: equal rank, 1: fresh task ranks higher
  function automatic int compare_urgency(input task_t held, input task_t fresh);
    if (held.mandatory != fresh.mandatory) begin
      return held.mandatory ? -1 : 1;
    end
    if (held.due_month != fresh.due_month) begin
      return (held.due_month < fresh.due_month) ? -1 : 1;
    end
    if (held.due_day != fresh.due_day) begin
      return (held.due_day < fresh.due_day) ? -1 : 1;
    end
    if (held.due_minute != fresh.due_minute) begin
      return (held.due_minute < fresh.due_minute) ? -1 : 1;
    end
    return 0;
  endfunction

  // Apply one word to our queue copy and build the front report it should give
  function automatic void apply_task_op(input in_word_t w, output out_word_t r);
    task_t fresh;
    int    slot;
    logic  turned_away;
    fresh.mandatory  = w.mandatory;
    fresh.due_month  = w.due_month;
    fresh.due_day    = w.due_day;
    fresh.due_minute = w.due_minute;
    fresh.task_tag   = w.task_tag;
    turned_away      = 1'b0;
    if (w.action == ACT_INSERT) begin
      if (held_count >= DEPTH) begin
        turned_away = 1'b1;
      end else begin
        // new task goes ahead of the first held task it does not lose to
        slot = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (compare_urgency(held_tasks[i], fresh) >= 0) slot = i;
        end
        if (slot < held_count && compare_urgency(held_tasks[slot], fresh) == 0) begin
          tie_inserts++;
        end
        for (int i = held_count; i > slot; i--) held_tasks[i] = held_tasks[i - 1];
        held_tasks[slot] = fresh;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        turned_away = 1'b1;
      end else begin
        for (int i = 0; i + 1 < held_count; i++) held_tasks[i] = held_tasks[i + 1];
        held_count--;
      end
    end
    r = '0;
    if (held_count > 0) begin
      r.front_valid     = 1'b1;
      r.front_mandatory = held_tasks[0].mandatory;
      r.front_month     = held_tasks[0].due_month;
      r.front_day       = held_tasks[0].due_day;
      r.front_minute    = held_tasks[0].due_minute;
      r.front_tag       = held_tasks[0].task_tag;
    end
    r.occupancy = held_count[OCC_W-1:0];
    r.is_full   = (held_count == DEPTH);
    r.refused   = turned_away;
    if (turned_away) refusals++;
    if (r.is_full) full_hits++;
  endfunction

  function automatic in_word_t task_word(input logic act, input logic mand,
                                         input logic [3:0] month,
                                         input logic [4:0] day,
                                         input logic [10:0] minute,
                                         input logic [15:0] tag);
    in_word_t w;
    w.action     = act;
    w.mandatory  = mand;
    w.due_month  = month;
    w.due_day    = day;
    w.due_minute = minute;
    w.task_tag   = tag;
    return w;
  endfunction

  // tight keys: a handful of distinct ranks, so ties are frequent
  function automatic in_word_t random_word(input logic act, input bit tight);
    in_word_t w;
    w.action    = act;
    w.mandatory = 1'($urandom_range(0, 1));
    w.task_tag  = 16'($urandom);
    if (tight) begin
      w.due_month  = 4'($urandom_range(1, 2));
      w.due_day    = 5'($urandom_range(1, 2));
      w.due_minute = 11'($urandom_range(0, 1));
    end else if ($urandom_range(0, 9) == 0) begin
      w.due_month  = 4'($urandom);
      w.due_day    = 5'($urandom);
      w.due_minute = 11'($urandom);
    end else begin
      w.due_month  = 4'($urandom_range(1, 12));
      w.due_day    = 5'($urandom_range(1, 31));
      w.due_minute = 11'($urandom_range(0, 1439));
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Hold start high until the word is taken, then log its expected report
  task automatic send_word(input in_word_t w);
    out_word_t r;
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_task_op(w, r);
    front_reports_due.push_back(r);
    words_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start   <= 1'b0;
      in_word <= random_word($urandom_range(0, 1), 1'b0);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_reports();
    start <= 1'b0;
    @(posedge clk);
    while (front_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes_and_ties();
    send_word(task_word(ACT_REMOVE, 1'b0, 4'd0, 5'd0, 11'd0, 16'h0000));
    send_word(task_word(ACT_INSERT, 1'b0, 4'd15, 5'd31, 11'd2047, 16'hffff));
    send_word(task_word(ACT_INSERT, 1'b0, 4'd0, 5'd0, 11'd0, 16'h0000));
    send_word(task_word(ACT_INSERT, 1'b1, 4'd15, 5'd31, 11'd2047, 16'h1234));
    send_word(task_word(ACT_INSERT, 1'b1, 4'd12, 5'd1, 11'd1439, 16'h0001));
    send_word(task_word(ACT_INSERT, 1'b1, 4'd12, 5'd1, 11'd1439, 16'h0002));
    send_word(task_word(ACT_INSERT, 1'b1, 4'd12, 5'd1, 11'd1438, 16'h0003));
    send_word(task_word(ACT_INSERT, 1'b0, 4'd0, 5'd0, 11'd0, 16'haaaa));
    send_word(task_word(ACT_INSERT, 1'b1, 4'd0, 5'd0, 11'd0, 16'h5555));
    send_word(task_word(ACT_INSERT, 1'b1, 4'b1010, 5'b10101, 11'b10101010101, 16'h5a5a));
    send_word(task_word(ACT_INSERT, 1'b1, 4'b0101, 5'b01010, 11'b01010101010, 16'ha5a5));
    // drain in order, then one remove too many
    for (int i = 0; i < 11; i++) begin
      send_word(random_word(ACT_REMOVE, 1'b0));
    end
    wait_for_reports();
  endtask

  task automatic test_capacity_limits();
    for (int i = 0; i < DEPTH; i++) send_word(random_word(ACT_INSERT, 1'b1));
    send_word(random_word(ACT_INSERT, 1'b0));
    send_word(random_word(ACT_INSERT, 1'b1));
    send_word(random_word(ACT_REMOVE, 1'b0));
    send_word(random_word(ACT_INSERT, 1'b1));
    for (int i = 0; i < DEPTH + 1; i++) send_word(random_word(ACT_REMOVE, 1'b0));
    wait_for_reports();
  endtask

  task automatic run_phase(input int words, input int insert_pct, input bit tight,
                           input bit gaps);
    logic act;
    for (int i = 0; i < words; i++) begin
      act = ($urandom_range(1, 100) <= insert_pct) ? ACT_INSERT : ACT_REMOVE;
      send_word(random_word(act, tight));
      if (gaps) pause_sender(pick_gap());
    end
  endtask

  task automatic test_random_traffic();
    int insert_pct;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          insert_pct = 85;
        end
        1: begin
          insert_pct = 50;
        end
        2: begin
          insert_pct = 15;
        end
        default: begin
          insert_pct = $urandom_range(30, 70);
        end
      endcase
      run_phase(PHASE_WORDS, insert_pct, p[1], (p % 3) != 2);
      // let everything settle now and then
      if (p % 4 == 3) wait_for_reports();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (front_reports_due.size() == 0) begin
        $display("%0t ns: unexpected report word %h", $time, out_word);
        mismatches++;
      end else begin
        want = front_reports_due.pop_front();
        reports_checked++;
        check_field("front_valid", 32'(want.front_valid), 32'(out_word.front_valid));
        check_field("front_mandatory", 32'(want.front_mandatory),
                    32'(out_word.front_mandatory));
        check_field("front_month", 32'(want.front_month), 32'(out_word.front_month));
        check_field("front_day", 32'(want.front_day), 32'(out_word.front_day));
        check_field("front_minute", 32'(want.front_minute), 32'(out_word.front_minute));
        check_field("front_tag", 32'(want.front_tag), 32'(out_word.front_tag));
        check_field("occupancy", 32'(want.occupancy), 32'(out_word.occupancy));
        check_field("is_full", 32'(want.is_full), 32'(out_word.is_full));
        check_field("refused", 32'(want.refused), 32'(out_word.refused));
      end
    end
  end

  // Progress watchdog: any taken or reported word resets the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    held_count  = 0;
    words_sent  = 0;
    refusals    = 0;
    full_hits   = 0;
    tie_inserts = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes_and_ties();
    test_capacity_limits();
    test_random_traffic();

    wait_for_reports();
    repeat (4) @(posedge clk);

    $display("Sent %0d words, checked %0d reports: %0d refusals, %0d full reports,",
             words_sent, reports_checked, refusals, full_hits);
    $display("%0d equal-rank inserts, %0d mismatches", tie_inserts, mismatches);
    if (mismatches == 0 && front_reports_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
